// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with an implication from a trigger.
`define ASSERT_IMPL(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/nsfc_pkg.sv =====
`default_nettype none
package nsfc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;

  localparam int unsigned ADDR_CHARS = 5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_DOLLAR = 3'd1;
  localparam logic [2:0] ST_NO_STAR   = 3'd2;
  localparam logic [2:0] ST_SHORT_CS  = 3'd3;
  localparam logic [2:0] ST_BAD_HEX   = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;
  localparam logic [2:0] ST_SHORT_ADR = 3'd7;

  localparam logic [2:0] KIND_OTHER = 3'd0;
  localparam logic [2:0] KIND_GGA   = 3'd1;
  localparam logic [2:0] KIND_GSA   = 3'd2;
  localparam logic [2:0] KIND_GSV   = 3'd3;
  localparam logic [2:0] KIND_RMC   = 3'd4;

  // Classified character word handed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_cr;
    logic       is_lf;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       hex_bad;
    logic [3:0] hex_val;
  } nsfc_item_t;

endpackage
`default_nettype wire

// ===== src/nsfc_front.sv =====
`default_nettype none
module nsfc_front
  import nsfc_pkg::*;
(
  input  wire logic [7:0] in_rx_byte,
  output nsfc_item_t      item
);

  always_comb begin
    item.ch        = in_rx_byte;
    item.is_cr     = (in_rx_byte == CH_CR);
    item.is_lf     = (in_rx_byte == CH_LF);
    item.is_dollar = (in_rx_byte == CH_DOLLAR);
    item.is_star   = (in_rx_byte == CH_STAR);
    item.is_comma  = (in_rx_byte == CH_COMMA);
    item.hex_bad   = 1'b0;
    item.hex_val   = 4'd0;
    if (in_rx_byte >= 8'h30 && in_rx_byte <= 8'h39) begin
      item.hex_val = in_rx_byte[3:0];
    end else if ((in_rx_byte >= 8'h41 && in_rx_byte <= 8'h46) ||
                 (in_rx_byte >= 8'h61 && in_rx_byte <= 8'h66)) begin
      // 'A'..'F' and 'a'..'f' share the low three bits: 1..6
      item.hex_val = 4'(in_rx_byte[2:0] + 3'd1) + 4'd8;
    end else begin
      item.hex_bad = 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/nsfc_queue.sv =====
`default_nettype none
module nsfc_queue
  import nsfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire nsfc_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output nsfc_item_t      head_item
);

  nsfc_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/nsfc_back.sv =====
`default_nettype none
module nsfc_back
  import nsfc_pkg::*;
#(
  parameter int unsigned MAX_LINE = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       head_valid,
  input  wire nsfc_item_t head_item,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_line_status,
  output logic [2:0]      out_sentence_kind,
  output logic [7:0]      out_talker_first,
  output logic [7:0]      out_talker_second,
  output logic [7:0]      out_computed_checksum,
  output logic [7:0]      out_payload_length
);

  localparam int unsigned LW = $clog2(MAX_LINE + 1);
  localparam logic [LW-1:0] MAX_CNT = LW'(MAX_LINE);

  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          sd_r, sd_nxt;
  logic          star_r, star_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [LW-1:0] spos_r, spos_nxt;
  logic [1:0]    ndig_r, ndig_nxt;
  logic [4:0]    dig0_r, dig0_nxt;
  logic [4:0]    dig1_r, dig1_nxt;
  logic [7:0]    addr_r [ADDR_CHARS];
  logic [7:0]    addr_nxt [ADDR_CHARS];
  logic [2:0]    alen_r, alen_nxt;
  logic          aclosed_r, aclosed_nxt;

  logic          out_valid_r;
  logic [2:0]    status_r, kind_r;
  logic [7:0]    tk1_r, tk2_r, cs_r, plen_r;

  logic          emits, out_free;
  logic [2:0]    status_c, kind_c;
  logic [7:0]    received;

  assign emits    = head_item.is_lf && (cnt_r != '0);
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = head_valid && (!emits || out_free);

  // status and kind of the line held now, used when a newline closes it
  always_comb begin
    received = {dig0_r[3:0], dig1_r[3:0]};
    kind_c   = KIND_OTHER;
    if (!sd_r)                     status_c = ST_NO_DOLLAR;
    else if (!star_r)              status_c = ST_NO_STAR;
    else if (ndig_r < 2'd2)        status_c = ST_SHORT_CS;
    else if (dig0_r[4] || dig1_r[4]) status_c = ST_BAD_HEX;
    else if (received != xor_r)    status_c = ST_MISMATCH;
    else if (spos_r == '0)         status_c = ST_EMPTY;
    else if (alen_r < 3'd5)        status_c = ST_SHORT_ADR;
    else                           status_c = ST_OK;
    if (status_c == ST_OK && alen_r == 3'd5) begin
      if (addr_r[2] == CH_G && addr_r[3] == CH_G && addr_r[4] == CH_A) kind_c = KIND_GGA;
      else if (addr_r[2] == CH_G && addr_r[3] == CH_S && addr_r[4] == CH_A) kind_c = KIND_GSA;
      else if (addr_r[2] == CH_G && addr_r[3] == CH_S && addr_r[4] == CH_V) kind_c = KIND_GSV;
      else if (addr_r[2] == CH_R && addr_r[3] == CH_M && addr_r[4] == CH_C) kind_c = KIND_RMC;
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    sd_nxt      = sd_r;
    star_nxt    = star_r;
    xor_nxt     = xor_r;
    spos_nxt    = spos_r;
    ndig_nxt    = ndig_r;
    dig0_nxt    = dig0_r;
    dig1_nxt    = dig1_r;
    addr_nxt    = addr_r;
    alen_nxt    = alen_r;
    aclosed_nxt = aclosed_r;

    if (pop && !head_item.is_cr) begin
      // newline ends the line, '$' restarts it, overflow drops it
      if (head_item.is_lf || head_item.is_dollar || cnt_r >= MAX_CNT) begin
        cnt_nxt     = '0;
        sd_nxt      = 1'b0;
        star_nxt    = 1'b0;
        xor_nxt     = 8'd0;
        spos_nxt    = '0;
        ndig_nxt    = 2'd0;
        dig0_nxt    = 5'd0;
        dig1_nxt    = 5'd0;
        for (int i = 0; i < ADDR_CHARS; i++) addr_nxt[i] = 8'd0;
        alen_nxt    = 3'd0;
        aclosed_nxt = 1'b0;
      end
      if (!head_item.is_lf && (head_item.is_dollar || cnt_r < MAX_CNT)) begin
        if (cnt_nxt == '0) begin
          sd_nxt = head_item.is_dollar;
        end else if (!star_nxt) begin
          if (head_item.is_star) begin
            star_nxt    = 1'b1;
            aclosed_nxt = 1'b1;
          end else begin
            xor_nxt  = xor_nxt ^ head_item.ch;
            spos_nxt = spos_nxt + LW'(1);
            if (!aclosed_nxt) begin
              if (head_item.is_comma) begin
                aclosed_nxt = 1'b1;
              end else begin
                if (alen_nxt < 3'd5) addr_nxt[alen_nxt] = head_item.ch;
                if (alen_nxt < 3'd6) alen_nxt = alen_nxt + 3'd1;
              end
            end
          end
        end else if (ndig_nxt == 2'd0) begin
          dig0_nxt = {head_item.hex_bad, head_item.hex_val};
          ndig_nxt = 2'd1;
        end else if (ndig_nxt == 2'd1) begin
          dig1_nxt = {head_item.hex_bad, head_item.hex_val};
          ndig_nxt = 2'd2;
        end
        cnt_nxt = cnt_nxt + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      sd_r      <= 1'b0;
      star_r    <= 1'b0;
      xor_r     <= 8'd0;
      spos_r    <= '0;
      ndig_r    <= 2'd0;
      dig0_r    <= 5'd0;
      dig1_r    <= 5'd0;
      for (int i = 0; i < ADDR_CHARS; i++) addr_r[i] <= 8'd0;
      alen_r    <= 3'd0;
      aclosed_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      sd_r      <= sd_nxt;
      star_r    <= star_nxt;
      xor_r     <= xor_nxt;
      spos_r    <= spos_nxt;
      ndig_r    <= ndig_nxt;
      dig0_r    <= dig0_nxt;
      dig1_r    <= dig1_nxt;
      addr_r    <= addr_nxt;
      alen_r    <= alen_nxt;
      aclosed_r <= aclosed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emits) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emits) begin
      status_r <= status_c;
      kind_r   <= kind_c;
      tk1_r    <= addr_r[0];
      tk2_r    <= addr_r[1];
      cs_r     <= xor_r;
      plen_r   <= 8'(spos_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_line_status       = status_r;
  assign out_sentence_kind     = kind_r;
  assign out_talker_first      = tk1_r;
  assign out_talker_second     = tk2_r;
  assign out_computed_checksum = cs_r;
  assign out_payload_length    = plen_r;

endmodule
`default_nettype wire

// ===== src/nmea_sentence_framer_checker.sv =====
`default_nettype none
// NMEA 0183 sentence framer and checksum checker. Takes one received byte per
// cycle while in_stall is low, and reports one status word per nonempty line when a
// newline arrives: status, sentence kind, talker characters, computed XOR
// checksum and payload length. Bytes pass through a classifier, a two-word
// queue and the line tracker; the result word is valid from the clock edge
// after the line tracker takes the newline and is held in an output register, so input
// keeps flowing while a result waits to be taken, until the next newline
// reaches the line tracker; the queue then fills and in_stall rises. Carriage
// returns are dropped, '$' restarts the line, and a line longer than MAX_LINE
// bytes is discarded. No clearing pass after reset.
module nmea_sentence_framer_checker
  import nsfc_pkg::*;
#(
  parameter int unsigned MAX_LINE = 128
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_line_status,
  output logic [2:0]      out_sentence_kind,
  output logic [7:0]      out_talker_first,
  output logic [7:0]      out_talker_second,
  output logic [7:0]      out_computed_checksum,
  output logic [7:0]      out_payload_length
);

  nsfc_item_t front_item, head_item;
  logic       q_full, head_valid, pop;

  nsfc_front u_front (
    .in_rx_byte (in_rx_byte),
    .item       (front_item)
  );

  nsfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  assign in_stall = q_full;

  nsfc_back #(.MAX_LINE(MAX_LINE)) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .head_valid            (head_valid),
    .head_item             (head_item),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_line_status       (out_line_status),
    .out_sentence_kind     (out_sentence_kind),
    .out_talker_first      (out_talker_first),
    .out_talker_second     (out_talker_second),
    .out_computed_checksum (out_computed_checksum),
    .out_payload_length    (out_payload_length)
  );

endmodule
`default_nettype wire

// ===== src/nsfc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module nsfc_checker
  import nsfc_pkg::*;
#(
  parameter int unsigned MAX_LINE = 128
) (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_line_status,
  input wire logic [2:0] out_sentence_kind,
  input wire logic [7:0] out_payload_length
);

  // a stalled word stays up
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "out word dropped")

  // kind only reported for good sentences
  `ASSERT_IMPL(a_kind_ok, clk, rst_n, out_valid && out_line_status != ST_OK, out_sentence_kind == KIND_OTHER, "kind on bad line")

  `ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_sentence_kind <= KIND_RMC, "kind out of range")

  // payload excludes the leading byte, so it stays below the line limit
  `ASSERT_IMPL(a_len_bound, clk, rst_n, out_valid, 32'(out_payload_length) < MAX_LINE, "payload too long")

  `ASSERT_IMPL(a_ok_nonempty, clk, rst_n, out_valid && out_line_status == ST_OK, out_payload_length >= 8'd5, "ok line too short")

endmodule

bind nmea_sentence_framer_checker nsfc_checker #(.MAX_LINE(MAX_LINE)) u_nsfc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_line_status    (out_line_status),
  .out_sentence_kind  (out_sentence_kind),
  .out_payload_length (out_payload_length)
);
`default_nettype wire
